### rtl/gcd_pkg.sv
package gcd_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int ANG_W        = 36;              // angle and CORDIC datapath width
  localparam int SQ_W         = 64;              // square root working width
  localparam int SQRT_STEPS   = SQ_W / 2;
  localparam int FRAC         = 30;

  localparam logic [31:0] DEG_RAD_M = 32'd4024455254;   // pi * 2^61 / 1.8e9
  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ANG_W-1:0] GAIN_INV    = 36'sd652032874;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam logic signed [34:0] HALF_TURN = 35'sd1800000000;
  localparam logic signed [34:0] FULL_TURN = 35'sd3600000000;
  localparam logic [22:0] RADIUS_RST = 23'd6371000;

  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic ang_t atan_at(input int i);
    ang_t v;
    case (i)
      0: v = 36'sd843314857;
      1: v = 36'sd497837829;
      2: v = 36'sd263043837;
      3: v = 36'sd133525159;
      4: v = 36'sd67021687;
      5: v = 36'sd33543516;
      6: v = 36'sd16775851;
      7: v = 36'sd8388437;
      8: v = 36'sd4194283;
      9: v = 36'sd2097149;
      default: v = (i <= FRAC) ? (ang_t'(1) << (FRAC - i)) : '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/gcd_sincos.sv
module gcd_sincos
  import gcd_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  ang_t ang,
  output ang_t cos_o,
  output ang_t sin_o
);

  ang_t x_r [0:CORDIC_STEPS];
  ang_t y_r [0:CORDIC_STEPS];
  ang_t z_r [0:CORDIC_STEPS];
  logic flip_r [0:CORDIC_STEPS];

  // fold into [-pi/2, pi/2]; the half turn flips both outputs
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_INV;
      y_r[0] <= '0;
      if (ang > HALF_PI_Q30) begin
        z_r[0]    <= ang - PI_Q30;
        flip_r[0] <= 1'b1;
      end else if (ang < -HALF_PI_Q30) begin
        z_r[0]    <= ang + PI_Q30;
        flip_r[0] <= 1'b1;
      end else begin
        z_r[0]    <= ang;
        flip_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][ANG_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_at(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_at(i);
        end
      end
    end
  end

  assign cos_o = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
  assign sin_o = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];

endmodule

### rtl/gcd_arc.sv
module gcd_arc
  import gcd_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] a,
  output ang_t        angle
);

  logic [SQ_W-1:0] na_r [0:SQRT_STEPS];
  logic [SQ_W-1:0] ra_r [0:SQRT_STEPS];
  logic [SQ_W-1:0] nb_r [0:SQRT_STEPS];
  logic [SQ_W-1:0] rb_r [0:SQRT_STEPS];
  ang_t vx_r [0:CORDIC_STEPS];
  ang_t vy_r [0:CORDIC_STEPS];
  ang_t vz_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      na_r[0] <= SQ_W'(a) << FRAC;
      nb_r[0] <= SQ_W'(ONE_Q30 - a) << FRAC;
      ra_r[0] <= '0;
      rb_r[0] <= '0;
    end
  end

  // one result bit per stage for both roots
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (na_r[i] >= ra_r[i] + BIT) begin
          na_r[i+1] <= na_r[i] - (ra_r[i] + BIT);
          ra_r[i+1] <= (ra_r[i] >> 1) + BIT;
        end else begin
          na_r[i+1] <= na_r[i];
          ra_r[i+1] <= ra_r[i] >> 1;
        end
        if (nb_r[i] >= rb_r[i] + BIT) begin
          nb_r[i+1] <= nb_r[i] - (rb_r[i] + BIT);
          rb_r[i+1] <= (rb_r[i] >> 1) + BIT;
        end else begin
          nb_r[i+1] <= nb_r[i];
          rb_r[i+1] <= rb_r[i] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= ang_t'(rb_r[SQRT_STEPS][FRAC:0]);
      vy_r[0] <= ang_t'(ra_r[SQRT_STEPS][FRAC:0]);
      vz_r[0] <= '0;
    end
  end

  // vectoring: drive y to zero, z gathers atan2(sqrt(a), sqrt(1-a))
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][ANG_W-1]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + atan_at(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - atan_at(i);
        end
      end
    end
  end

  assign angle = vz_r[CORDIC_STEPS];

endmodule

### rtl/great_circle_distance.sv
// Haversine distance pipeline.
// Input stream: one item per point pair on in_tdata; result stream: distance
// in whole metres on out_tdata. cfg_wr_en/cfg_wr_data load the sphere radius
// (metres); write it only while no item is in flight.
// Pipeline depth is set by the sin/cos CORDIC, the digit-by-digit square
// roots and the atan2 CORDIC, each one iteration per stage.
// Throughput: one item per cycle while the receiver does not stall. All
// stages share one advance enable, so a new item enters whenever the output
// register is empty or being taken in the same cycle.
// When the receiver stalls with a result waiting, the whole pipe holds; no
// item is dropped or duplicated and in_tready falls in that cycle.
// Reset clears the valid chain (no results pending) and loads the radius
// with 6371000 m.
module great_circle_distance
  import gcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [30:0] first_latitude, [62:31] first_longitude,
  // [93:63] second_latitude, [125:94] second_longitude, [127:126] zero
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [24:0] distance_m, [31:25] zero
  output logic [31:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [22:0]  cfg_wr_data
);

  localparam int TOTAL = 13 + 2 * CORDIC_STEPS + SQRT_STEPS;
  localparam int A_IDX = 8 + CORDIC_STEPS;

  typedef logic signed [34:0] dif_t;

  function automatic dif_t wrap_turn(input dif_t d);
    dif_t r;
    if (d >= HALF_TURN) r = d - FULL_TURN;
    else if (d < -HALF_TURN) r = d + FULL_TURN;
    else r = d;
    return r;
  endfunction

  logic [TOTAL-1:0] v_r;
  logic             en;
  logic [22:0]      radius_r;

  logic signed [30:0] lat1_r, lat2_r;
  logic signed [31:0] lon1_r, lon2_r;
  logic [30:0]        mag_r  [0:3];
  logic [3:0]         neg2_r, neg3_r;
  logic [62:0]        prod_r [0:3];
  ang_t               ang_r  [0:3];
  ang_t               ang_nxt [0:3];
  ang_t               cos_w  [0:3];
  ang_t               sin_w  [0:3];
  logic signed [31:0] s1_r, s2_r, c1_r, c2_r;
  logic signed [63:0] p1, p2, pc, pm;
  logic signed [33:0] t1_r, t2_r, cc_r, t1d_r, m_r;
  logic signed [35:0] a_sum;
  logic [30:0]        a_r, a_nxt;
  ang_t               angle_w;
  logic [31:0]        zc;
  logic [54:0]        mult_r;
  logic [55:0]        rnd;
  logic [24:0]        dist_r;
  dif_t               dlat, dlon;

  assign out_tvalid = v_r[TOTAL-1];
  assign en         = ~out_tvalid | out_tready;
  assign in_tready  = en;
  assign out_tdata  = {7'b0, dist_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      radius_r <= RADIUS_RST;
    end else begin
      if (en) v_r <= {v_r[TOTAL-2:0], in_tvalid};
      if (cfg_wr_en) radius_r <= cfg_wr_data;
    end
  end

  always_comb begin
    dlat = wrap_turn(dif_t'(lat2_r) - dif_t'(lat1_r));
    dlon = wrap_turn(dif_t'(lon2_r) - dif_t'(lon1_r));
  end

  // order of lanes: half dlat, half dlon, lat1, lat2
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [63:0] sum;
      logic [32:0] mag_u;
      sum = {1'b0, prod_r[k]} + ((k < 2) ? 64'h8000_0000 : 64'h4000_0000);
      mag_u = (k < 2) ? {1'b0, sum[63:32]} : sum[63:31];
      ang_nxt[k] = neg3_r[k] ? -ang_t'(mag_u) : ang_t'(mag_u);
    end
  end

  always_comb begin
    p1 = s1_r * s1_r;
    p2 = s2_r * s2_r;
    pc = c1_r * c2_r;
    pm = $signed(cc_r[31:0]) * $signed(t2_r[31:0]);
    a_sum = 36'(t1d_r) + 36'(m_r);
    if (a_sum < 0) a_nxt = '0;
    else if (a_sum > 36'(ONE_Q30)) a_nxt = ONE_Q30;
    else a_nxt = a_sum[30:0];
    zc = angle_w[ANG_W-1] ? '0 : angle_w[31:0];
    rnd = {1'b0, mult_r} + (56'd1 << 28);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= in_tdata[30:0];
      lon1_r <= in_tdata[62:31];
      lat2_r <= in_tdata[93:63];
      lon2_r <= in_tdata[125:94];

      mag_r[0] <= dlat[34] ? 31'(-dlat) : 31'(dlat);
      mag_r[1] <= dlon[34] ? 31'(-dlon) : 31'(dlon);
      mag_r[2] <= lat1_r[30] ? 31'(-lat1_r) : 31'(lat1_r);
      mag_r[3] <= lat2_r[30] ? 31'(-lat2_r) : 31'(lat2_r);
      neg2_r   <= {lat2_r[30], lat1_r[30], dlon[34], dlat[34]};

      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= 63'(mag_r[k]) * 63'(DEG_RAD_M);
        ang_r[k]  <= ang_nxt[k];
      end
      neg3_r <= neg2_r;

      s1_r <= sin_w[0][31:0];
      s2_r <= sin_w[1][31:0];
      c1_r <= cos_w[2][31:0];
      c2_r <= cos_w[3][31:0];

      t1_r <= p1[63:30];
      t2_r <= p2[63:30];
      cc_r <= pc[63:30];

      t1d_r <= t1_r;
      m_r   <= pm[63:30];

      a_r <= a_nxt;

      mult_r <= 55'(radius_r) * 55'(zc);
      dist_r <= rnd[53:29];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_sc
    gcd_sincos u_sc (
      .clk   (clk),
      .en    (en),
      .ang   (ang_r[k]),
      .cos_o (cos_w[k]),
      .sin_o (sin_w[k])
    );
  end

  gcd_arc u_arc (
    .clk   (clk),
    .en    (en),
    .a     (a_r),
    .angle (angle_w)
  );

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[A_IDX] |-> (a_r <= ONE_Q30))
    else $error("haversine term out of [0,1]");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid chain moved during stall");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

endmodule

### tb/great_circle_distance_tb.sv
`timescale 1ns / 1ps

module great_circle_distance_tb
  import gcd_pkg::*;
();

  typedef struct packed {
    logic signed [31:0] lon2;
    logic signed [30:0] lat2;
    logic signed [31:0] lon1;
    logic signed [30:0] lat1;
  } pair_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [22:0]  cfg_wr_data = '0;

  great_circle_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  pair_t       pair_q[$];
  logic [24:0] dist_q[$];
  longint      radius_m;
  int          mismatches = 0;
  bit          stim_done = 1'b0;
  bit          in_taken = 1'b0;

  logic [22:0] radius_m_list[5] = '{23'd6371000, 23'd6000000, 23'd7000000, 23'd1,
                                    23'd6378137};

  // ---------------- prediction ----------------
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint deg_to_q30(longint u, int sh);
    longint unsigned m;
    longint unsigned mag;
    longint unsigned r;
    m = (64'h3243F6A8885A308D * 2 + 900000000) / 1800000000;
    mag = (u < 0) ? -u : u;
    r = (mag * m + (64'd1 << (sh - 1))) >> sh;
    return (u < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void rotate(longint z0, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874; y = 0; z = z0; flip = 0;
    if (z > 1686629713) begin z -= 64'sd3373259426; flip = 1; end
    else if (z < -1686629713) begin z += 64'sd3373259426; flip = 1; end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i); dy = floor_shr(x, i);
      if (z >= 0) begin x -= dx; y += dy; z -= atan_step(i); end
      else begin x += dx; y -= dy; z += atan_step(i); end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i); dy = floor_shr(x, i);
      if (y >= 0) begin x += dx; y -= dy; z += atan_step(i); end
      else begin x -= dx; y += dy; z -= atan_step(i); end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0; b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin n -= res + b; res = (res >> 1) + b; end
      else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint wrap_half_turn(longint d);
    if (d >= 1800000000) return d - 64'sd3600000000;
    if (d < -1800000000) return d + 64'sd3600000000;
    return d;
  endfunction

  function automatic logic [24:0] haversine_m(pair_t p, longint r);
    longint dlat, dlon, cu, su, s1, s2, c1, c2, t1, t2, cc, a, z;
    longint unsigned ra, rb, d;
    dlat = wrap_half_turn(longint'(p.lat2) - longint'(p.lat1));
    dlon = wrap_half_turn(longint'(p.lon2) - longint'(p.lon1));
    rotate(deg_to_q30(dlat, 32), cu, s1);
    rotate(deg_to_q30(dlon, 32), cu, s2);
    rotate(deg_to_q30(p.lat1, 31), c1, su);
    rotate(deg_to_q30(p.lat2, 31), c2, su);
    t1 = floor_shr(s1 * s1, 30);
    t2 = floor_shr(s2 * s2, 30);
    cc = floor_shr(c1 * c2, 30);
    a = t1 + floor_shr(cc * t2, 30);
    if (a < 0) a = 0;
    if (a > 1073741824) a = 1073741824;
    ra = int_sqrt(longint'(a) << 30);
    rb = int_sqrt(longint'(1073741824 - a) << 30);
    z = vector_angle(ra, rb);
    if (z < 0) z = 0;
    d = (longint'(r) * z + (64'd1 << 28)) >> 29;
    return d[24:0];
  endfunction

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;

  // whether the offered item went in at the last rising edge
  always @(posedge clk) in_taken <= in_tvalid && in_tready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pair_q.size() > 0) begin
        in_tdata <= {2'b00, pair_q.pop_front()};
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern with phases of no stalls
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    case ((rx_phase / 200) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      dist_q.push_back(haversine_m(pair_t'(in_tdata[125:0]), radius_m));
    if (rst_n && out_tvalid && out_tready) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: distance_m %0d", out_tdata[24:0]);
      end else begin
        logic [24:0] want;
        want = dist_q.pop_front();
        if (out_tdata[24:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance_m mismatch: expected %0d, got %0d", want, out_tdata[24:0]);
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic pair_t rand_pair(int mode);
    pair_t p;
    logic [127:0] raw;
    case (mode)
      0: begin // raw bits, any value of the fields
        raw = {$urandom, $urandom, $urandom, $urandom};
        p = raw[125:0];
      end
      1: begin // nearby points
        p.lat1 = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
        p.lon1 = $signed($urandom_range(0, 32'd3600000000)) - 1800000000;
        p.lat2 = 31'(p.lat1 + $signed($urandom_range(0, 2000000)) - 1000000);
        p.lon2 = p.lon1 + $signed($urandom_range(0, 2000000)) - 1000000;
      end
      default: begin
        p.lat1 = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
        p.lon1 = $signed($urandom_range(0, 32'd3600000000)) - 1800000000;
        p.lat2 = 31'($signed($urandom_range(0, 1800000000)) - 900000000);
        p.lon2 = $signed($urandom_range(0, 32'd3600000000)) - 1800000000;
      end
    endcase
    return p;
  endfunction

  task automatic add_pair(int la1, int lo1, int la2, int lo2);
    pair_t p;
    p.lat1 = 31'(la1); p.lon1 = lo1; p.lat2 = 31'(la2); p.lon2 = lo2;
    pair_q.push_back(p);
  endtask

  task automatic drain_then_radius(logic [22:0] r);
    while (pair_q.size() > 0 || in_tvalid || dist_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    radius_m = r;
  endtask

  initial begin
    radius_m = 6371000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, poles, antipodes, date-line wrap, out-of-range latitudes
    add_pair(0, 0, 0, 0);
    add_pair(900000000, 0, -900000000, 0);
    add_pair(0, 0, 0, 1800000000);
    add_pair(0, -1800000000, 0, 1800000000);
    add_pair(0, 1799999999, 0, -1799999999);
    add_pair(0, -1800000000, 0, 1799999999);
    add_pair(-900000000, -1800000000, 900000000, 1800000000);
    add_pair(515000000, -1200000, 488600000, 23500000);
    add_pair(1073741823, 2147483647, -1073741824, -2147483648);
    add_pair(-1073741824, -2147483648, 1073741823, 2147483647);
    add_pair(1000000000, 0, -1000000000, 0);
    add_pair(0, 0, 1, 1);
    add_pair(450000000, 900000000, -450000000, -900000000);
    add_pair(0, 0, 0, -1800000000);
    drain_then_radius(23'd0);
    add_pair(0, 0, 0, 1800000000);
    add_pair(100000000, 0, 0, 0);
    drain_then_radius(23'h7FFFFF);
    add_pair(0, 0, 0, 1800000000);
    add_pair(900000000, 0, -900000000, 0);
    add_pair(-1073741824, -2147483648, 1073741823, 2147483647);

    foreach (radius_m_list[k]) begin
      drain_then_radius(radius_m_list[k]);
      for (int n = 0; n < 100; n++) pair_q.push_back(rand_pair($urandom_range(0, 3) % 3));
    end
    stim_done = 1'b1;
  end

  // ---------------- end of run ----------------
  initial begin
    wait (stim_done);
    while (pair_q.size() > 0 || in_tvalid || dist_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && dist_q.size() == 0)
      $display("great_circle_distance test passed");
    else
      $display("great_circle_distance test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("great_circle_distance test failed");
    $finish;
  end

endmodule
